[rtl/lsmt_pkg.sv]
// ----------------------------------------------------------------------------
// lsmt_pkg
// Types and constants shared by the LCD scan mode timer modules.
// ----------------------------------------------------------------------------
package lsmt_pkg;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_SEARCH = 2'd2,
		MODE_RENDER = 2'd3
	} mode_t;

	localparam logic [3:0] OFF_CONTROL  = 4'd0;
	localparam logic [3:0] OFF_STATUS   = 4'd1;
	localparam logic [3:0] OFF_SCROLL_Y = 4'd2;
	localparam logic [3:0] OFF_SCROLL_X = 4'd3;
	localparam logic [3:0] OFF_LINE     = 4'd4;
	localparam logic [3:0] OFF_LINE_CMP = 4'd5;
	localparam logic [3:0] OFF_BG_PAL   = 4'd7;
	localparam logic [3:0] OFF_OBJ_PAL0 = 4'd8;
	localparam logic [3:0] OFF_OBJ_PAL1 = 4'd9;
	localparam logic [3:0] OFF_WIN_Y    = 4'd10;
	localparam logic [3:0] OFF_WIN_X    = 4'd11;

	localparam logic [8:0] DOTS_PER_TICK = 9'd4;
	localparam logic [8:0] DOTS_SEARCH   = 9'd80;
	localparam logic [8:0] DOTS_RENDER   = 9'd172;
	localparam logic [8:0] DOTS_HBLANK   = 9'd204;
	localparam logic [8:0] DOTS_LINE     = 9'd456;

	localparam int CTRL_ON_BIT     = 7;
	localparam int ST_CMP_FLAG_BIT = 2;
	localparam int ST_EN_HBLANK    = 3;
	localparam int ST_EN_VBLANK    = 4;
	localparam int ST_EN_SEARCH    = 5;
	localparam int ST_EN_CMP       = 6;
	localparam logic [7:0] ST_ENABLES = 8'h78;
	localparam logic [7:0] READ_UNKNOWN = 8'hFF;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] reg_offset;
		logic [7:0] write_data;
	} item_t;

	typedef struct packed {
		logic       frame_done;
		logic       line_done;
		logic       vblank_irq;
		logic       stat_irq;
		logic [7:0] line_number;
		logic [1:0] lcd_mode;
		logic       access_error;
		logic [7:0] read_data;
	} result_t;

endpackage

[rtl/lcd_scan_mode_timer.sv]
// ----------------------------------------------------------------------------
// lcd_scan_mode_timer
// Mode and status timing of a four-mode LCD scan controller.
// ----------------------------------------------------------------------------
// Slave stream: each transaction is a tick of four dots, a register write or
// a register read (kind in s_tuser). Master stream: one result transaction
// per input, carrying read data, error flag, mode, line number and the
// interrupt and strobe pulses caused by that input.
// A transaction is held in the input register and then evaluated into the
// result register, which drives m_*. Throughput: one transaction per cycle
// while m_tready is high; the timer and register window are evaluated
// combinationally between the two registers.
// Reset clears the valid flags and the engine registers; the display is off and the mode is hblank.
// When m_tready is low the result register holds, the input register keeps
// one more transaction, and s_tready drops once both are full.
// ----------------------------------------------------------------------------
module lcd_scan_mode_timer #(
	parameter int VISIBLE_LINES = 144,
	parameter int TOTAL_LINES   = 154
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // reg_offset[3:0], write_data[11:4], zero pad
	input  logic [1:0]  s_tuser,   // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_data[7:0], access_error[8], lcd_mode[10:9], line_number[18:11],
	// stat_irq[19], vblank_irq[20], line_done[21], frame_done[22], zero pad
	output logic [23:0] m_tdata
);
	import lsmt_pkg::*;

	item_t   item_s1;
	logic    vld_s1;
	result_t res_s2, res_d;
	logic    vld_s2;
	logic    adv;

	assign adv      = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= '{kind: kind_t'(s_tuser), reg_offset: s_tdata[3:0],
				write_data: s_tdata[11:4]};
		end
	end

	lsmt_engine #(
		.VISIBLE_LINES(VISIBLE_LINES),
		.TOTAL_LINES  (TOTAL_LINES)
	) u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (adv),
		.item  (item_s1),
		.res   (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (m_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_d;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {1'b0, res_s2};

	a_frame_in_vblank: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && res_s2.frame_done |->
			res_s2.vblank_irq && res_s2.lcd_mode == MODE_VBLANK)
		else $error("frame done outside vblank entry");

	a_line_done_mode: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && res_s2.line_done |->
			res_s2.lcd_mode == MODE_SEARCH || res_s2.lcd_mode == MODE_VBLANK)
		else $error("line done with wrong next mode");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv |=> vld_s1 && $stable(item_s1))
		else $error("input register lost a pending transaction");

endmodule

[rtl/lsmt_engine.sv]
// ----------------------------------------------------------------------------
// lsmt_engine
// Register window and line/mode timer; applies one transaction per fire.
// ----------------------------------------------------------------------------
module lsmt_engine #(
	parameter int VISIBLE_LINES = 144,
	parameter int TOTAL_LINES   = 154
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  lsmt_pkg::item_t  item,
	output lsmt_pkg::result_t res
);
	import lsmt_pkg::*;

	localparam logic [7:0] VIS_LINE = 8'(VISIBLE_LINES);
	localparam logic [7:0] TOT_LINE = 8'(TOTAL_LINES);

	logic [8:0] dot_q, dot_d;
	logic [7:0] line_q, line_d;
	logic [7:0] ctrl_q, ctrl_d;
	logic [7:0] status_q, status_d;
	logic [7:0] cmp_q, cmp_d;
	logic [7:0] scy_q, scy_d;
	logic [7:0] scx_q, scx_d;
	logic [7:0] bgp_q, bgp_d;
	logic [7:0] obp0_q, obp0_d;
	logic [7:0] obp1_q, obp1_d;
	logic [7:0] wy_q, wy_d;
	logic [7:0] wx_q, wx_d;
	logic [8:0] dt;
	mode_t      mode, nmode;

	always_comb begin
		dot_d    = dot_q;
		line_d   = line_q;
		ctrl_d   = ctrl_q;
		status_d = status_q;
		cmp_d    = cmp_q;
		scy_d    = scy_q;
		scx_d    = scx_q;
		bgp_d    = bgp_q;
		obp0_d   = obp0_q;
		obp1_d   = obp1_q;
		wy_d     = wy_q;
		wx_d     = wx_q;
		res      = '0;
		mode     = mode_t'(status_q[1:0]);
		nmode    = mode;
		dt       = dot_q + DOTS_PER_TICK;
		case (item.kind)
			KIND_TICK: begin
				if (ctrl_q[CTRL_ON_BIT]) begin
					unique case (mode)
						MODE_SEARCH: begin
							if (dt == DOTS_PER_TICK && status_q[ST_EN_CMP] && cmp_q == line_q)
								res.stat_irq = 1'b1;
							if (dt >= DOTS_SEARCH) begin
								nmode = MODE_RENDER;
								dt    = '0;
							end
						end
						MODE_RENDER: begin
							if (dt >= DOTS_RENDER) begin
								nmode = MODE_HBLANK;
								dt    = '0;
								res.stat_irq = status_q[ST_EN_HBLANK];
							end
						end
						MODE_HBLANK: begin
							if (dt >= DOTS_HBLANK) begin
								res.line_done = 1'b1;
								dt     = '0;
								line_d = line_q + 8'd1;
								if (line_d == VIS_LINE) begin
									nmode = MODE_VBLANK;
									res.vblank_irq = 1'b1;
									res.frame_done = 1'b1;
									res.stat_irq   = status_q[ST_EN_VBLANK];
								end else begin
									nmode = MODE_SEARCH;
									res.stat_irq = status_q[ST_EN_SEARCH];
								end
							end
						end
						MODE_VBLANK: begin
							if (dt >= DOTS_LINE) begin
								dt     = '0;
								line_d = line_q + 8'd1;
								if (line_d == TOT_LINE || line_d == 8'd0) begin
									line_d = '0;
									nmode  = MODE_SEARCH;
									res.stat_irq = status_q[ST_EN_SEARCH];
								end
							end
						end
						default: ;
					endcase
					dot_d    = dt;
					status_d = {status_q[7:3], line_d == cmp_q, nmode};
				end
			end
			KIND_WRITE: begin
				unique case (item.reg_offset)
					OFF_CONTROL: begin
						if (ctrl_q[CTRL_ON_BIT] && !item.write_data[CTRL_ON_BIT]) begin
							dot_d    = '0;
							line_d   = '0;
							status_d = {status_q[7:2], MODE_SEARCH};
						end
						ctrl_d = item.write_data;
					end
					OFF_STATUS:
						status_d = (status_q & ~ST_ENABLES) | (item.write_data & ST_ENABLES);
					OFF_SCROLL_Y: scy_d  = item.write_data;
					OFF_SCROLL_X: scx_d  = item.write_data;
					OFF_LINE_CMP: cmp_d  = item.write_data;
					OFF_BG_PAL:   bgp_d  = item.write_data;
					OFF_OBJ_PAL0: obp0_d = item.write_data;
					OFF_OBJ_PAL1: obp1_d = item.write_data;
					OFF_WIN_Y:    wy_d   = item.write_data;
					OFF_WIN_X:    wx_d   = item.write_data;
					default:      res.access_error = 1'b1;
				endcase
			end
			KIND_READ: begin
				unique case (item.reg_offset)
					OFF_CONTROL:  res.read_data = ctrl_q;
					OFF_STATUS:   res.read_data = status_q;
					OFF_SCROLL_Y: res.read_data = scy_q;
					OFF_SCROLL_X: res.read_data = scx_q;
					OFF_LINE:     res.read_data = line_q;
					OFF_LINE_CMP: res.read_data = cmp_q;
					OFF_BG_PAL:   res.read_data = bgp_q;
					OFF_OBJ_PAL0: res.read_data = obp0_q;
					OFF_OBJ_PAL1: res.read_data = obp1_q;
					OFF_WIN_Y:    res.read_data = wy_q;
					OFF_WIN_X:    res.read_data = wx_q;
					default: begin
						res.read_data    = READ_UNKNOWN;
						res.access_error = 1'b1;
					end
				endcase
			end
			default: ;
		endcase
		res.lcd_mode    = status_d[1:0];
		res.line_number = line_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q    <= '0;
			line_q   <= '0;
			ctrl_q   <= '0;
			status_q <= '0;
			cmp_q    <= '0;
			scy_q    <= '0;
			scx_q    <= '0;
			bgp_q    <= '0;
			obp0_q   <= '0;
			obp1_q   <= '0;
			wy_q     <= '0;
			wx_q     <= '0;
		end else if (fire) begin
			dot_q    <= dot_d;
			line_q   <= line_d;
			ctrl_q   <= ctrl_d;
			status_q <= status_d;
			cmp_q    <= cmp_d;
			scy_q    <= scy_d;
			scx_q    <= scx_d;
			bgp_q    <= bgp_d;
			obp0_q   <= obp0_d;
			obp1_q   <= obp1_d;
			wy_q     <= wy_d;
			wx_q     <= wx_d;
		end
	end

endmodule
